// ----- sv/bay_protection_autoreclose_sequencer_defines.svh -----
// Assertion macros for the bay protection and auto-reclose sequencer.
// Clocked on clk, disabled while rst_n is low; no other dependencies.
`ifndef BAY_PROTECTION_AUTORECLOSE_SEQUENCER_DEFINES_SVH
`define BAY_PROTECTION_AUTORECLOSE_SEQUENCER_DEFINES_SVH

`ifndef ASSERT_OFF
// property that must hold at every edge
`define BPAR_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// consequent that must hold in the cycle after the antecedent
`define BPAR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define BPAR_ASSERT(lbl, prop, msg)
`define BPAR_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

// ----- sv/bpar_pkg.sv -----
// Package for the bay protection and auto-reclose sequencer: word types,
// operation, state and status codes, timer widths and helper functions.
// No dependencies.
package bpar_pkg;

    // timer and delay widths
    localparam int TIMER_BITS = 16;
    localparam int DELAY_BITS = 16;
    localparam int CMP_BITS   = (TIMER_BITS > DELAY_BITS) ? TIMER_BITS : DELAY_BITS;

    localparam logic [TIMER_BITS-1:0] TIMER_MAX     = '1;
    localparam logic [DELAY_BITS-1:0] TRF_TRIP_MS   = DELAY_BITS'(10);
    localparam logic [DELAY_BITS-1:0] FINAL_TRIP_MS = DELAY_BITS'(100);
    localparam logic [3:0]            ATTEMPT_MAX   = 4'd15;

    // operation codes
    localparam logic [2:0] OP_TICK   = 3'd0;
    localparam logic [2:0] OP_INJECT = 3'd1;
    localparam logic [2:0] OP_CLEAR  = 3'd2;
    localparam logic [2:0] OP_RESET  = 3'd3;
    localparam logic [2:0] OP_BUSBAR = 3'd4;

    // bay kinds
    localparam logic [1:0] KIND_LINE        = 2'd0;
    localparam logic [1:0] KIND_TRANSFORMER = 2'd1;
    localparam logic [1:0] KIND_COUPLER     = 2'd2;

    // fault zones with their own delay register
    localparam logic [2:0] ZONE_1 = 3'd1;
    localparam logic [2:0] ZONE_3 = 3'd3;
    localparam logic [2:0] ZONE_4 = 3'd4;

    // register indexes
    localparam logic [2:0] CFG_BAY_KIND      = 3'd0;
    localparam logic [2:0] CFG_RECLOSE_LIMIT = 3'd1;
    localparam logic [2:0] CFG_ZONE1_DELAY   = 3'd2;
    localparam logic [2:0] CFG_ZONE2_DELAY   = 3'd3;
    localparam logic [2:0] CFG_ZONE3_DELAY   = 3'd4;
    localparam logic [2:0] CFG_ZONE4_DELAY   = 3'd5;
    localparam logic [2:0] CFG_DEAD_TIME     = 3'd6;
    localparam logic [2:0] CFG_RECLAIM_TIME  = 3'd7;

    // reported protection state codes
    localparam logic [2:0] PS_IDLE     = 3'd0;
    localparam logic [2:0] PS_STARTED  = 3'd1;
    localparam logic [2:0] PS_TRIPPED  = 3'd2;
    localparam logic [2:0] PS_DEAD     = 3'd3;
    localparam logic [2:0] PS_SYNC     = 3'd4;
    localparam logic [2:0] PS_RECLOSED = 3'd5;
    localparam logic [2:0] PS_LOCKOUT  = 3'd6;

    // reclose status codes
    localparam logic [1:0] RC_READY    = 2'd0;
    localparam logic [1:0] RC_DEAD     = 2'd1;
    localparam logic [1:0] RC_RECLOSED = 2'd2;
    localparam logic [1:0] RC_FINAL    = 2'd3;

    // sequencer state, one-hot
    typedef enum logic [6:0] {
        S_IDLE     = 7'b0000001,
        S_STARTED  = 7'b0000010,
        S_TRIPPED  = 7'b0000100,
        S_DEAD     = 7'b0001000,
        S_SYNC     = 7'b0010000,
        S_RECLOSED = 7'b0100000,
        S_LOCKOUT  = 7'b1000000
    } seq_state_t;

    // input word
    typedef struct packed {
        logic [2:0] operation;
        logic [2:0] zone_sel;
    } in_word_t;

    // result word
    typedef struct packed {
        logic       accepted;
        logic [2:0] relay_state;
        logic       breaker_closed;
        logic       trip_flag;
        logic       operate_flag;
        logic [1:0] reclose_status;
    } out_word_t;

    // state to reported code
    function automatic logic [2:0] state_code(input seq_state_t s);
        logic [2:0] code;
        unique case (s)
            S_IDLE:     code = PS_IDLE;
            S_STARTED:  code = PS_STARTED;
            S_TRIPPED:  code = PS_TRIPPED;
            S_DEAD:     code = PS_DEAD;
            S_SYNC:     code = PS_SYNC;
            S_RECLOSED: code = PS_RECLOSED;
            S_LOCKOUT:  code = PS_LOCKOUT;
            default:    code = PS_IDLE;
        endcase
        return code;
    endfunction

    // timer has reached a delay
    function automatic logic timer_reached(input logic [TIMER_BITS-1:0] t,
                                           input logic [DELAY_BITS-1:0] d);
        return CMP_BITS'(t) >= CMP_BITS'(d);
    endfunction

endpackage

// ----- sv/bay_protection_autoreclose_sequencer.sv -----
// Top level of the bay protection and auto-reclose sequencer.
// Depends on bpar_pkg and bay_protection_autoreclose_sequencer_defines.svh.
//
// Usage:
//   Input channel in_valid/in_ready/in_data carries one word per item: a
//   one-millisecond tick or a command (inject fault, clear fault, reset,
//   busbar trip). Every input word yields exactly one result word on
//   out_valid/out_ready/out_data, showing the bay state after the item.
//   The configuration port (cfg_write, cfg_index, cfg_data) writes one
//   register per enabled cycle; write it only while the block is idle.
//   A word accepted at an edge has its result in the output register from
//   that edge on. Throughput is one word per cycle while out_ready holds,
//   set by the single state update between the state registers and the
//   result register. in_ready is high whenever the output register is
//   empty or being taken in the same cycle, so a stalled receiver holds
//   the result and stalls the input after at most one word.
//   Reset clears the sequencer to idle with the breaker closed, loads the
//   default delays, and empties the output register.
`include "bay_protection_autoreclose_sequencer_defines.svh"

module bay_protection_autoreclose_sequencer (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  bpar_pkg::in_word_t   in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output bpar_pkg::out_word_t  out_data,
    input  logic                 cfg_write,
    input  logic [2:0]           cfg_index,
    input  logic [15:0]          cfg_data
);

    // configuration registers
    logic [1:0]                      bay_kind_reg;
    logic [3:0]                      reclose_limit_reg;
    logic [bpar_pkg::DELAY_BITS-1:0] zone1_delay_reg;
    logic [bpar_pkg::DELAY_BITS-1:0] zone2_delay_reg;
    logic [bpar_pkg::DELAY_BITS-1:0] zone3_delay_reg;
    logic [bpar_pkg::DELAY_BITS-1:0] zone4_delay_reg;
    logic [bpar_pkg::DELAY_BITS-1:0] dead_time_reg;
    logic [bpar_pkg::DELAY_BITS-1:0] reclaim_time_reg;

    // sequencer state
    bpar_pkg::seq_state_t            seq_state_reg, seq_state_next;
    logic [bpar_pkg::TIMER_BITS-1:0] elapsed_reg, elapsed_next;
    logic                            fault_reg, fault_next;
    logic [2:0]                      zone_reg, zone_next;
    logic [3:0]                      attempt_reg, attempt_next;
    logic                            breaker_reg, breaker_next;
    logic                            trip_reg, trip_next;
    logic                            operate_reg, operate_next;
    logic [1:0]                      reclose_reg, reclose_next;
    logic                            acc_next;

    // result register
    logic                            out_valid_reg;
    bpar_pkg::out_word_t             out_data_reg;
    bpar_pkg::out_word_t             out_data_next;

    logic                            in_accept;
    logic [bpar_pkg::TIMER_BITS-1:0] elapsed_inc;
    logic [bpar_pkg::DELAY_BITS-1:0] zone_delay;

    assign in_ready  = !out_valid_reg || out_ready;
    assign in_accept = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bay_kind_reg      <= bpar_pkg::KIND_LINE;
            reclose_limit_reg <= 4'd1;
            zone1_delay_reg   <= bpar_pkg::DELAY_BITS'(0);
            zone2_delay_reg   <= bpar_pkg::DELAY_BITS'(400);
            zone3_delay_reg   <= bpar_pkg::DELAY_BITS'(1000);
            zone4_delay_reg   <= bpar_pkg::DELAY_BITS'(500);
            dead_time_reg     <= bpar_pkg::DELAY_BITS'(800);
            reclaim_time_reg  <= bpar_pkg::DELAY_BITS'(5000);
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                bpar_pkg::CFG_BAY_KIND:      bay_kind_reg      <= cfg_data[1:0];
                bpar_pkg::CFG_RECLOSE_LIMIT: reclose_limit_reg <= cfg_data[3:0];
                bpar_pkg::CFG_ZONE1_DELAY:   zone1_delay_reg   <= cfg_data;
                bpar_pkg::CFG_ZONE2_DELAY:   zone2_delay_reg   <= cfg_data;
                bpar_pkg::CFG_ZONE3_DELAY:   zone3_delay_reg   <= cfg_data;
                bpar_pkg::CFG_ZONE4_DELAY:   zone4_delay_reg   <= cfg_data;
                bpar_pkg::CFG_DEAD_TIME:     dead_time_reg     <= cfg_data;
                bpar_pkg::CFG_RECLAIM_TIME:  reclaim_time_reg  <= cfg_data;
                default:                     bay_kind_reg      <= bay_kind_reg;
            endcase
        end
    end

    // saturating millisecond count and stored zone delay
    assign elapsed_inc = (elapsed_reg == bpar_pkg::TIMER_MAX) ? elapsed_reg
                                                               : elapsed_reg + 1'b1;

    always_comb
    begin
        case (zone_reg)
            bpar_pkg::ZONE_1: zone_delay = zone1_delay_reg;
            bpar_pkg::ZONE_3: zone_delay = zone3_delay_reg;
            bpar_pkg::ZONE_4: zone_delay = zone4_delay_reg;
            default:          zone_delay = zone2_delay_reg;
        endcase
    end

    // state update for one input word
    always_comb
    begin
        seq_state_next = seq_state_reg;
        elapsed_next   = elapsed_reg;
        fault_next     = fault_reg;
        zone_next      = zone_reg;
        attempt_next   = attempt_reg;
        breaker_next   = breaker_reg;
        trip_next      = trip_reg;
        operate_next   = operate_reg;
        reclose_next   = reclose_reg;
        acc_next       = 1'b1;

        case (in_data.operation)
            bpar_pkg::OP_TICK:
            begin
                elapsed_next = elapsed_inc;
                if (bay_kind_reg == bpar_pkg::KIND_LINE)
                begin
                    unique case (seq_state_reg)
                        bpar_pkg::S_STARTED:
                        begin
                            if (bpar_pkg::timer_reached(elapsed_inc, zone_delay))
                            begin
                                operate_next   = 1'b1;
                                trip_next      = 1'b1;
                                breaker_next   = 1'b0;
                                seq_state_next = bpar_pkg::S_TRIPPED;
                                elapsed_next   = '0;
                            end
                        end
                        bpar_pkg::S_TRIPPED:
                        begin
                            elapsed_next = '0;
                            if (reclose_limit_reg != 4'd0 && attempt_reg < reclose_limit_reg)
                            begin
                                seq_state_next = bpar_pkg::S_DEAD;
                                reclose_next   = bpar_pkg::RC_DEAD;
                            end
                            else
                            begin
                                seq_state_next = bpar_pkg::S_LOCKOUT;
                            end
                        end
                        bpar_pkg::S_DEAD:
                        begin
                            if (bpar_pkg::timer_reached(elapsed_inc, dead_time_reg))
                            begin
                                seq_state_next = bpar_pkg::S_SYNC;
                                elapsed_next   = '0;
                            end
                        end
                        bpar_pkg::S_SYNC:
                        begin
                            breaker_next = 1'b1;
                            if (attempt_reg != bpar_pkg::ATTEMPT_MAX)
                            begin
                                attempt_next = attempt_reg + 1'b1;
                            end
                            seq_state_next = bpar_pkg::S_RECLOSED;
                            elapsed_next   = '0;
                            reclose_next   = bpar_pkg::RC_RECLOSED;
                        end
                        bpar_pkg::S_RECLOSED:
                        begin
                            // fault still there: final trip; gone: reclaim to idle
                            if (fault_reg &&
                                bpar_pkg::timer_reached(elapsed_inc, bpar_pkg::FINAL_TRIP_MS))
                            begin
                                breaker_next   = 1'b0;
                                seq_state_next = bpar_pkg::S_LOCKOUT;
                                elapsed_next   = '0;
                                reclose_next   = bpar_pkg::RC_FINAL;
                            end
                            else if (!fault_reg &&
                                     bpar_pkg::timer_reached(elapsed_inc, reclaim_time_reg))
                            begin
                                operate_next   = 1'b0;
                                trip_next      = 1'b0;
                                reclose_next   = bpar_pkg::RC_READY;
                                seq_state_next = bpar_pkg::S_IDLE;
                                attempt_next   = 4'd0;
                            end
                        end
                        default:
                        begin
                            seq_state_next = seq_state_reg;
                        end
                    endcase
                end
                else if ((bay_kind_reg == bpar_pkg::KIND_TRANSFORMER &&
                          bpar_pkg::timer_reached(elapsed_inc, bpar_pkg::TRF_TRIP_MS)) ||
                         (bay_kind_reg == bpar_pkg::KIND_COUPLER &&
                          bpar_pkg::timer_reached(elapsed_inc, zone2_delay_reg)))
                begin
                    // transformer and coupler bays trip straight to lockout
                    if (seq_state_reg == bpar_pkg::S_STARTED)
                    begin
                        operate_next   = 1'b1;
                        trip_next      = 1'b1;
                        breaker_next   = 1'b0;
                        seq_state_next = bpar_pkg::S_LOCKOUT;
                        elapsed_next   = '0;
                    end
                end
            end
            bpar_pkg::OP_INJECT:
            begin
                if (seq_state_reg != bpar_pkg::S_IDLE)
                begin
                    acc_next = 1'b0;
                end
                else
                begin
                    fault_next     = 1'b1;
                    zone_next      = in_data.zone_sel;
                    attempt_next   = 4'd0;
                    seq_state_next = bpar_pkg::S_STARTED;
                    elapsed_next   = '0;
                end
            end
            bpar_pkg::OP_CLEAR:
            begin
                fault_next = 1'b0;
            end
            bpar_pkg::OP_RESET:
            begin
                seq_state_next = bpar_pkg::S_IDLE;
                fault_next     = 1'b0;
                attempt_next   = 4'd0;
                breaker_next   = 1'b1;
                trip_next      = 1'b0;
                if (reclose_limit_reg != 4'd0)
                begin
                    reclose_next = bpar_pkg::RC_READY;
                end
            end
            bpar_pkg::OP_BUSBAR:
            begin
                if (breaker_reg)
                begin
                    breaker_next   = 1'b0;
                    seq_state_next = bpar_pkg::S_LOCKOUT;
                end
            end
            default:
            begin
                acc_next = 1'b1;
            end
        endcase
    end

    // result word from the updated state
    always_comb
    begin
        out_data_next.accepted       = acc_next;
        out_data_next.relay_state    = bpar_pkg::state_code(seq_state_next);
        out_data_next.breaker_closed = breaker_next;
        out_data_next.trip_flag      = trip_next;
        out_data_next.operate_flag   = operate_next;
        out_data_next.reclose_status = reclose_next;
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_state_reg <= bpar_pkg::S_IDLE;
            elapsed_reg   <= '0;
            fault_reg     <= 1'b0;
            zone_reg      <= 3'd0;
            attempt_reg   <= 4'd0;
            breaker_reg   <= 1'b1;
            trip_reg      <= 1'b0;
            operate_reg   <= 1'b0;
            reclose_reg   <= bpar_pkg::RC_READY;
        end
        else if (in_accept)
        begin
            seq_state_reg <= seq_state_next;
            elapsed_reg   <= elapsed_next;
            fault_reg     <= fault_next;
            zone_reg      <= zone_next;
            attempt_reg   <= attempt_next;
            breaker_reg   <= breaker_next;
            trip_reg      <= trip_next;
            operate_reg   <= operate_next;
            reclose_reg   <= reclose_next;
        end
    end

    // output valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_accept)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // output word
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            out_data_reg <= out_data_next;
        end
    end

    // checks
    `BPAR_ASSERT(a_lockout_breaker_open,
        (seq_state_reg != bpar_pkg::S_LOCKOUT) || !breaker_reg,
        "breaker closed in lockout")
    `BPAR_ASSERT_NEXT(a_accept_gives_word, in_accept, out_valid_reg,
        "accepted word gave no result")
    `BPAR_ASSERT(a_dead_entry_timer_clear,
        !(seq_state_reg == bpar_pkg::S_DEAD && $past(seq_state_reg) != bpar_pkg::S_DEAD)
            || (elapsed_reg == '0),
        "dead time entered with running timer")

endmodule
